[rtl/tnmh_pkg.sv]
// tnmh_pkg: shared types for the top-n min-heap tracker
// no dependencies
`timescale 1ns / 1ps
package tnmh_pkg;
  localparam int unsigned ValueW = 32;
  localparam int unsigned TimeW  = 64;
  // heap positions, enough for TOP_COUNT up to 1024
  localparam int unsigned PosW   = 11;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [TimeW-1:0]         time_t;

  typedef struct packed {
    value_t value;
    time_t  stamp;
  } entry_t;

  typedef struct packed {
    value_t sample_value;
    time_t  sample_time;
  } in_item_t;

  typedef struct packed {
    logic   accepted;
    value_t evicted_value;
    time_t  evicted_time;
    value_t min_value;
    time_t  min_time;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;

  localparam entry_t ENTRY_RESET = '{value: {1'b1, {(ValueW-1){1'b0}}}, stamp: '0};
endpackage

[rtl/tnmh_if.sv]
// tnmh_if: valid/ready channel carrying one transaction payload
// no dependencies
`timescale 1ns / 1ps
interface tnmh_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/tnmh_cell.sv]
// tnmh_cell: one heap level; holds that level's entries and sifts the token down one level
// depends on tnmh_pkg
`timescale 1ns / 1ps
module tnmh_cell #(
  parameter int unsigned LEVEL = 1,
  parameter int unsigned TOP_COUNT = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tok_in_valid,
  input  tnmh_pkg::entry_t          tok_in_entry,
  input  logic [tnmh_pkg::PosW-1:0] tok_in_pos,
  output logic                      tok_out_valid,
  output tnmh_pkg::entry_t          tok_out_entry,
  output logic [tnmh_pkg::PosW-1:0] tok_out_pos,
  output logic                      up_wr,
  output tnmh_pkg::entry_t          up_entry,
  input  logic                      dn_wr,
  input  tnmh_pkg::entry_t          dn_entry
);
  import tnmh_pkg::*;
  // positions 2^LEVEL .. 2^(LEVEL+1)-1 clipped to TOP_COUNT
  localparam int unsigned Base = 1 << LEVEL;
  localparam int unsigned Last = ((2*Base - 1) < TOP_COUNT) ? (2*Base - 1) : TOP_COUNT;
  localparam int unsigned N    = Last - Base + 1;
  localparam int unsigned IdxW = (N > 1) ? $clog2(N) : 1;

  entry_t mem_r [N];

  logic [PosW-1:0] lpos, rpos, pick_pos;
  logic [IdxW-1:0] il, ir, ip, iw;
  logic            has_l, has_r, leaf, do_swap;
  entry_t          el, er, pick;

  // token carries the sifting entry and its parent position one level up
  always_comb begin
    lpos  = {tok_in_pos[PosW-2:0], 1'b0};
    rpos  = lpos | PosW'(1);
    has_l = lpos <= PosW'(TOP_COUNT);
    has_r = rpos <= PosW'(TOP_COUNT);
    il    = IdxW'(lpos - PosW'(Base));
    ir    = IdxW'(rpos - PosW'(Base));
    el    = has_l ? mem_r[il] : ENTRY_RESET;
    er    = has_r ? mem_r[ir] : ENTRY_RESET;
    if (!has_r) begin
      pick = el; pick_pos = lpos;
    end else if (el.value == er.value) begin
      if (el.stamp > er.stamp) begin
        pick = el; pick_pos = lpos;
      end else begin
        pick = er; pick_pos = rpos;
      end
    end else if (el.value < er.value) begin
      pick = el; pick_pos = lpos;
    end else begin
      pick = er; pick_pos = rpos;
    end
    leaf     = pick_pos > PosW'(TOP_COUNT / 2);
    ip       = IdxW'(pick_pos - PosW'(Base));
    iw       = IdxW'(tok_out_pos - PosW'(Base));
    do_swap  = tok_in_valid && has_l && !(tok_in_entry.value < pick.value);
    // parent slot takes the child on a swap, else the sifting entry settles there
    up_wr    = tok_in_valid;
    up_entry = do_swap ? pick : tok_in_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_out_valid <= 1'b0;
      for (int unsigned i = 0; i < N; i++) mem_r[i] <= ENTRY_RESET;
    end else begin
      tok_out_valid <= do_swap && !leaf;
      if (do_swap && leaf) mem_r[ip] <= tok_in_entry;
      else if (dn_wr) mem_r[iw] <= dn_entry;
    end
    tok_out_entry <= tok_in_entry;
    tok_out_pos   <= pick_pos;
  end
endmodule

[rtl/top_n_min_heap_tracker_top.sv]
// top_n_min_heap_tracker_top: top-n min-heap tracker, one transaction in flight at a time
// a rejected sample needs no sift; an accepted one sends a sift token through the levels
// level cells, levels = floor(log2(TOP_COUNT)), the sift token walking one level cell a cycle
// a new transaction is taken only after the result of the last one has been handed out
// reset: synchronous active-low rst_n; every entry holds the most negative value, time zero
// depends on tnmh_pkg, tnmh_if, tnmh_cell
`timescale 1ns / 1ps
module top_n_min_heap_tracker_top #(
  parameter int unsigned TOP_COUNT = 64
) (
  input logic clk,
  input logic rst_n,
  tnmh_if.sink   in_ch,
  tnmh_if.source out_ch
);
  import tnmh_pkg::*;
  localparam int unsigned Levels = $clog2(TOP_COUNT + 1) - 1;

  state_t st_r, st_nxt;
  entry_t root_r;
  entry_t sample_r;
  logic   tok_valid_r;
  logic   acc_r;
  entry_t evict_r;

  logic            tv [Levels+1];
  entry_t          te [Levels+1];
  logic [PosW-1:0] tp [Levels+1];
  logic            uw [1:Levels+1];
  entry_t          ue [1:Levels+1];

  in_item_t it;
  logic     take;
  logic     acc;
  logic     busy;

  assign it   = in_ch.payload;
  assign take = in_ch.valid && in_ch.ready;
  assign acc  = !(it.sample_value < root_r.value);

  // level 0: root check; an accepted entry starts its sift at the root
  assign tv[0] = tok_valid_r;
  assign te[0] = sample_r;
  assign tp[0] = PosW'(1);
  assign uw[Levels+1] = 1'b0;
  assign ue[Levels+1] = ENTRY_RESET;

  for (genvar g = 1; g <= Levels; g++) begin : g_cell
    tnmh_cell #(.LEVEL(g), .TOP_COUNT(TOP_COUNT)) u_cell (
      .clk, .rst_n,
      .tok_in_valid(tv[g-1]), .tok_in_entry(te[g-1]), .tok_in_pos(tp[g-1]),
      .tok_out_valid(tv[g]), .tok_out_entry(te[g]), .tok_out_pos(tp[g]),
      .up_wr(uw[g]), .up_entry(ue[g]),
      .dn_wr(uw[g+1]), .dn_entry(ue[g+1])
    );
  end

  always_comb begin
    busy = 1'b0;
    for (int unsigned i = 0; i <= Levels; i++) busy = busy | tv[i];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_ch.valid) st_nxt = ST_RUN;
      ST_RUN:  if (!busy) st_nxt = ST_OUT;
      ST_OUT:  if (out_ch.ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready    = (st_r == ST_IDLE);
    out_ch.valid   = (st_r == ST_OUT);
    out_ch.payload = '{accepted: acc_r, evicted_value: evict_r.value,
                       evicted_time: evict_r.stamp, min_value: root_r.value,
                       min_time: root_r.stamp};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      root_r      <= ENTRY_RESET;
      tok_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      tok_valid_r <= take && acc;
      // the root takes what the first cell hands up
      if (uw[1]) root_r <= ue[1];
    end
    if (take) begin
      sample_r <= '{value: it.sample_value, stamp: it.sample_time};
      acc_r    <= acc;
      evict_r  <= acc ? root_r : '0;
    end
  end
endmodule

[sim/tb.sv]
// tb: self-checking bench for top_n_min_heap_tracker_top, table-driven directed
// transactions then random ones, checked against an in-bench heap predictor
// depends on tnmh_pkg, tnmh_if, top_n_min_heap_tracker_top
`timescale 1ns / 1ps
module tb;
  import tnmh_pkg::*;

  localparam int unsigned TopCount = 64;
  localparam int unsigned NumRandom = 600;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    value_t    sample_value;
    time_t     sample_time;
    bit        has_fixed;
    out_item_t fixed;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tnmh_if #(.payload_t(in_item_t))  in_ch ();
  tnmh_if #(.payload_t(out_item_t)) out_ch ();

  top_n_min_heap_tracker_top #(.TOP_COUNT(TopCount)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  value_t    pred_values[TopCount];
  time_t     pred_times[TopCount];
  out_item_t expected_q[$];
  stim_row_t rows[$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned accept_count;
  int unsigned cycle_count;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void heap_clear();
    for (int i = 0; i < TopCount; i++) begin
      pred_values[i] = ENTRY_RESET.value;
      pred_times[i]  = '0;
    end
  endfunction

  function automatic out_item_t heap_offer(value_t v, time_t t);
    out_item_t r;
    int unsigned cur;
    int unsigned lc;
    int unsigned rc;
    int unsigned pick;
    value_t tv;
    time_t tt;
    r = '0;
    if (!(v < pred_values[0])) begin
      r.accepted      = 1'b1;
      r.evicted_value = pred_values[0];
      r.evicted_time  = pred_times[0];
      pred_values[0]  = v;
      pred_times[0]   = t;
      cur = 1;
      while (cur * 2 <= TopCount) begin
        lc = cur * 2;
        rc = lc + 1;
        if (rc <= TopCount) begin
          if (pred_values[lc-1] == pred_values[rc-1])
            pick = (pred_times[lc-1] > pred_times[rc-1]) ? lc : rc;
          else
            pick = (pred_values[lc-1] < pred_values[rc-1]) ? lc : rc;
        end else begin
          pick = lc;
        end
        if (pred_values[cur-1] < pred_values[pick-1]) break;
        tv = pred_values[cur-1];
        tt = pred_times[cur-1];
        pred_values[cur-1]  = pred_values[pick-1];
        pred_times[cur-1]   = pred_times[pick-1];
        pred_values[pick-1] = tv;
        pred_times[pick-1]  = tt;
        cur = pick;
      end
    end
    r.min_value = pred_values[0];
    r.min_time  = pred_times[0];
    return r;
  endfunction

  function automatic void add_row(value_t v, time_t t, bit fx, out_item_t e);
    stim_row_t s;
    s.sample_value = v;
    s.sample_time  = t;
    s.has_fixed    = fx;
    s.fixed        = e;
    rows.push_back(s);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays high into the next transaction when there is no gap
  task automatic send(value_t v, time_t t);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{sample_value: v, sample_time: t};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // random value: fully random half the time, else small values, values near the minimum or extremes
  function automatic value_t pick_value();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 10) return {1'b1, 31'h0};
    if (k < 15) return {1'b0, {31{1'b1}}};
    if (k < 35) return value_t'($urandom_range(0, 15)) - 8;
    if (k < 50) return pred_values[0] + value_t'($urandom_range(0, 2)) - 1;
    return value_t'($urandom);
  endfunction

  function automatic time_t pick_time();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 2) return time_t'($urandom_range(0, 3));
    if (k < 3) return '1;
    return {$urandom, $urandom};
  endfunction

  // sink side: random stalls and checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected transaction %p", out_ch.payload);
        end else if (expected_q[0] !== out_ch.payload) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: exp %p got %p", expected_q[0], out_ch.payload);
          void'(expected_q.pop_front());
        end else begin
          void'(expected_q.pop_front());
        end
      end
    end
  end

  initial begin
    int unsigned s;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      s = gap_len();
      if (s == 0) out_ch.ready <= 1'b1;
      else begin
        out_ch.ready <= 1'b0;
        repeat (s) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_item_t e;
    out_item_t p;
    value_t    v;
    time_t     t;
    int unsigned burst;
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    rst_n          <= 1'b0;
    mismatch_count = 0;
    result_count   = 0;
    accept_count   = 0;
    cycle_count    = 0;
    heap_clear();

    // after reset: equal to the minimum is taken, evicting the reset entry
    e = '0;
    e.accepted = 1'b1; e.evicted_value = {1'b1, 31'h0};
    e.min_value = {1'b1, 31'h0};
    add_row({1'b1, 31'h0}, 64'd5, 1'b1, e);
    add_row({1'b0, {31{1'b1}}}, '1, 1'b0, '0);
    add_row(32'sd0, 64'd0, 1'b0, '0);
    add_row(-32'sd1, 64'h8000_0000_0000_0000, 1'b0, '0);
    // equal values, tie broken on timestamp
    for (int i = 0; i < 8; i++) add_row({1'b1, 31'h0}, 64'(i * 3 + 1), 1'b0, '0);
    for (int i = 0; i < 6; i++) add_row(32'sd7, 64'(i % 2), 1'b0, '0);
    add_row({1'b0, {31{1'b1}}}, 64'h5555_aaaa_5555_aaaa, 1'b0, '0);
    add_row(32'h5555_aaaa, 64'haaaa_5555_aaaa_5555, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      p = heap_offer(rows[i].sample_value, rows[i].sample_time);
      expected_q.push_back(rows[i].has_fixed ? rows[i].fixed : p);
      if (p.accepted) accept_count++;
      send(rows[i].sample_value, rows[i].sample_time);
    end

    // random part; the start of every hundred pushes the minimum high so rejects appear too
    for (int n = 0; n < NumRandom; n++) begin
      burst = (n % 100 < 20) ? 0 : 1;
      v = pick_value();
      t = pick_time();
      if (burst == 0 && $urandom_range(0, 1)) v = {1'b0, 31'($urandom_range(0, 32'h7fff_ffff))};
      p = heap_offer(v, t);
      expected_q.push_back(p);
      if (p.accepted) accept_count++;
      send(v, t);
    end
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("offered %0d samples, %0d accepted, %0d results checked",
             rows.size() + NumRandom, accept_count, result_count);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
